/* src/btmx_pkg.sv */
// Shared types and constants for the binary trie maximum-XOR block.
package btmx_pkg;

    localparam int DATA_W   = 32;
    localparam int STATUS_W = 2;

    localparam logic ACTION_INSERT = 1'b0;
    localparam logic ACTION_QUERY  = 1'b1;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK    = 2'd0,
        ST_EMPTY = 2'd1,
        ST_FULL  = 2'd2
    } status_t;

    typedef enum logic [1:0] {
        S_IDLE,
        S_WALK,
        S_DONE
    } state_t;

endpackage

/* src/binary_trie_max_xor.sv */
// Binary trie over keys in one node memory: insert and maximum-XOR query.
// A walking insert or query reads the node memory once per trie level, from the top key bit
// down, then loads its result into the output register; a refused or empty item skips the walk.
// One item at a time: s_axis_tready is high only while idle, and a finished item waits in its
// done state while a loaded result is still waiting for m_axis_tready.
// Reset (rst_n, asynchronous) empties the trie at once; no clearing pass of the node memory.
module binary_trie_max_xor #(
    parameter int KEY_BITS   = 32,
    parameter int NODE_COUNT = 4096
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           s_axis_tvalid,
    output logic                           s_axis_tready,
    input  logic [btmx_pkg::DATA_W-1:0]    s_axis_tdata,   // key
    input  logic                           s_axis_tuser,   // action
    output logic                           m_axis_tvalid,
    input  logic                           m_axis_tready,
    output logic [btmx_pkg::DATA_W-1:0]    m_axis_tdata,   // best_xor
    output logic [btmx_pkg::STATUS_W-1:0]  m_axis_tuser    // status
);

    localparam int IW = $clog2(NODE_COUNT);
    localparam int CW = $clog2(NODE_COUNT + 1);
    localparam int LW = (KEY_BITS > 1) ? $clog2(KEY_BITS) : 1;
    localparam int EW = 2 * IW;

    btmx_pkg::state_t  state_reg, state_next;
    btmx_pkg::status_t status_reg, status_next;

    logic                          action_reg, action_next;
    logic [btmx_pkg::DATA_W-1:0]   key_reg, key_next;
    logic [btmx_pkg::DATA_W-1:0]   acc_reg, acc_next;
    logic [LW-1:0]                 level_reg, level_next;
    logic [IW-1:0]                 cur_reg, cur_next;
    logic                          fresh_reg, fresh_next;
    logic [CW-1:0]                 nodes_used_reg, nodes_used_next;
    logic                          has_keys_reg, has_keys_next;

    logic                          out_valid_reg, out_valid_next;
    logic [btmx_pkg::DATA_W-1:0]   out_data_reg, out_data_next;
    logic [btmx_pkg::STATUS_W-1:0] out_status_reg, out_status_next;

    logic [EW-1:0] mem [NODE_COUNT];
    logic [EW-1:0] rd_data_reg;
    logic          rd_en;
    logic [IW-1:0] rd_addr;
    logic          wr_en;
    logic [IW-1:0] wr_addr;
    logic [EW-1:0] wr_data;

    logic          in_xfer;
    logic          store_full;
    logic [EW-1:0] kids;
    logic [IW-1:0] child0;
    logic [IW-1:0] child1;
    logic [IW-1:0] alloc;
    logic [IW-1:0] sel;
    logic [IW-1:0] other;
    logic [IW-1:0] nxt;
    logic          kbit;

    assign s_axis_tready = (state_reg == btmx_pkg::S_IDLE);
    assign in_xfer       = s_axis_tvalid && s_axis_tready;
    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_data_reg;
    assign m_axis_tuser  = out_status_reg;

    assign store_full = ({1'b0, nodes_used_reg} + (CW+1)'(KEY_BITS)) > (CW+1)'(NODE_COUNT);

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= btmx_pkg::S_IDLE;
            status_reg     <= btmx_pkg::ST_OK;
            action_reg     <= 1'b0;
            key_reg        <= '0;
            acc_reg        <= '0;
            level_reg      <= '0;
            cur_reg        <= '0;
            fresh_reg      <= 1'b0;
            nodes_used_reg <= CW'(1);
            has_keys_reg   <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            status_reg     <= status_next;
            action_reg     <= action_next;
            key_reg        <= key_next;
            acc_reg        <= acc_next;
            level_reg      <= level_next;
            cur_reg        <= cur_next;
            fresh_reg      <= fresh_next;
            nodes_used_reg <= nodes_used_next;
            has_keys_reg   <= has_keys_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_data_reg   <= out_data_next;
        out_status_reg <= out_status_next;
    end

    always_comb
    begin
        state_next      = state_reg;
        status_next     = status_reg;
        action_next     = action_reg;
        key_next        = key_reg;
        acc_next        = acc_reg;
        level_next      = level_reg;
        cur_next        = cur_reg;
        fresh_next      = fresh_reg;
        nodes_used_next = nodes_used_reg;
        has_keys_next   = has_keys_reg;
        out_valid_next  = out_valid_reg && !m_axis_tready;
        out_data_next   = out_data_reg;
        out_status_next = out_status_reg;

        rd_en   = 1'b0;
        rd_addr = '0;
        wr_en   = 1'b0;
        wr_addr = cur_reg;
        wr_data = '0;

        kids   = (fresh_reg || !has_keys_reg) ? '0 : rd_data_reg;
        child0 = kids[IW-1:0];
        child1 = kids[EW-1:IW];
        alloc  = nodes_used_reg[IW-1:0];
        kbit   = key_reg[level_reg];
        sel    = '0;
        other  = '0;
        nxt    = cur_reg;

        case (state_reg)
            btmx_pkg::S_IDLE:
            begin
                if (in_xfer)
                begin
                    action_next = s_axis_tuser;
                    key_next    = s_axis_tdata;
                    acc_next    = '0;
                    level_next  = LW'(KEY_BITS - 1);
                    cur_next    = '0;
                    fresh_next  = 1'b0;
                    status_next = btmx_pkg::ST_OK;
                    if (s_axis_tuser == btmx_pkg::ACTION_INSERT && store_full)
                    begin
                        status_next = btmx_pkg::ST_FULL;
                        state_next  = btmx_pkg::S_DONE;
                    end
                    else if (s_axis_tuser == btmx_pkg::ACTION_QUERY && !has_keys_reg)
                    begin
                        status_next = btmx_pkg::ST_EMPTY;
                        state_next  = btmx_pkg::S_DONE;
                    end
                    else
                    begin
                        rd_en      = 1'b1;
                        rd_addr    = '0;
                        state_next = btmx_pkg::S_WALK;
                    end
                end
            end

            btmx_pkg::S_WALK:
            begin
                if (action_reg == btmx_pkg::ACTION_INSERT)
                begin
                    sel = kbit ? child1 : child0;
                    nxt = sel;
                    if (sel == '0)
                    begin
                        nxt             = alloc;
                        wr_en           = 1'b1;
                        wr_data         = kbit ? {alloc, child0} : {child1, alloc};
                        nodes_used_next = nodes_used_reg + CW'(1);
                        fresh_next      = 1'b1;
                    end
                end
                else
                begin
                    sel   = kbit ? child0 : child1;
                    other = kbit ? child1 : child0;
                    if (sel != '0)
                    begin
                        acc_next[level_reg] = 1'b1;
                        nxt                 = sel;
                    end
                    else if (other != '0)
                    begin
                        nxt = other;
                    end
                end
                cur_next = nxt;
                if (level_reg == '0)
                begin
                    if (action_reg == btmx_pkg::ACTION_INSERT)
                    begin
                        has_keys_next = 1'b1;
                    end
                    state_next = btmx_pkg::S_DONE;
                end
                else
                begin
                    level_next = level_reg - LW'(1);
                    rd_en      = 1'b1;
                    rd_addr    = nxt;
                end
            end

            btmx_pkg::S_DONE:
            begin
                if (!out_valid_reg || m_axis_tready)
                begin
                    out_valid_next  = 1'b1;
                    out_data_next   = acc_reg;
                    out_status_next = status_reg;
                    state_next      = btmx_pkg::S_IDLE;
                end
            end

            default:
            begin
                state_next = btmx_pkg::S_IDLE;
            end
        endcase
    end

endmodule
